[rtl/bbmf_pkg.sv]
// Shared constants and types of the binary block majority filter.
package bbmf_pkg;

    // Default sizes of the column store and of the largest tile
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_MAX_TILE  = 16;

    // Fixed image and field sizes
    localparam int HEIGHT_LIMIT = 1024;
    localparam int ROW_W        = 10;
    localparam int TILE_IDX_W   = 10;
    localparam int PIXEL_W      = 8;
    localparam int FILL_W       = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_TILE_W = 5;
    localparam int CFG_DIM_W  = 11;

    // Register values after reset
    localparam int RST_TILE_SIZE    = 5;
    localparam int RST_IMAGE_WIDTH  = 640;
    localparam int RST_IMAGE_HEIGHT = 480;

    // Tile fill values
    localparam logic [FILL_W-1:0] FILL_WHITE = 8'd255;
    localparam logic [FILL_W-1:0] FILL_BLACK = 8'd0;

    // Result queue
    localparam int OUTQ_DEPTH = 3;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TILE_SIZE    = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } t_cfg_reg;

    // Per-pixel work handed from the position tracker to the accumulator
    typedef struct packed {
        logic                  count_en;
        logic                  first;
        logic                  white;
        logic                  emit;
        logic                  last;
        logic [ROW_W-1:0]      tile_row;
        logic [TILE_IDX_W-1:0] tile_col;
    } t_pix_op;

    // One decided tile
    typedef struct packed {
        logic [ROW_W-1:0]      tile_row;
        logic [TILE_IDX_W-1:0] tile_col;
        logic                  white_major;
        logic                  last;
    } t_result;

endpackage

[rtl/bbmf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bbmf_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bbmf_pos.sv]
// Raster position tracker: tile indices, tile membership and decision points.
module bbmf_pos #(
    parameter int MAX_WIDTH = bbmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_TILE  = bbmf_pkg::DEF_MAX_TILE
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_accept,
    input  logic [bbmf_pkg::PIXEL_W-1:0]           i_pixel,
    input  logic                                   i_frame_start,
    input  logic [$clog2(MAX_TILE+1)-1:0]          i_tile,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]         i_width,
    input  logic [bbmf_pkg::ROW_W:0]               i_height,
    output bbmf_pkg::t_pix_op                      o_op,
    output logic [$clog2(MAX_WIDTH)-1:0]           o_addr
);
    import bbmf_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int TW  = $clog2(MAX_TILE + 1);
    localparam int TOW = $clog2(MAX_TILE);
    localparam int HW  = ROW_W + 1;
    localparam int PCW = CW + 1 + TW;
    localparam int PRW = HW + TW;

    logic [CW-1:0]    r_pcol, n_pcol, e_pcol;
    logic [CW-1:0]    r_ctc,  n_ctc,  e_ctc;
    logic [TOW-1:0]   r_ocol, n_ocol, e_ocol;
    logic [ROW_W-1:0] r_prow, n_prow, e_prow;
    logic [ROW_W-1:0] r_ctr,  n_ctr,  e_ctr;
    logic [TOW-1:0]   r_orow, n_orow, e_orow;

    logic [PCW-1:0] col_prod;
    logic [PRW-1:0] row_prod;
    logic           col_fits, row_fits, col_last, row_last;
    logic           ocol_end, orow_end, pcol_end, prow_end;

    // Positions as seen by this pixel: a frame start clears them first
    always_comb begin
        e_pcol = i_frame_start ? '0 : r_pcol;
        e_ctc  = i_frame_start ? '0 : r_ctc;
        e_ocol = i_frame_start ? '0 : r_ocol;
        e_prow = i_frame_start ? '0 : r_prow;
        e_ctr  = i_frame_start ? '0 : r_ctr;
        e_orow = i_frame_start ? '0 : r_orow;
    end

    // Full-tile test: (index + 1) * tile must not pass the image edge
    always_comb begin
        col_prod = PCW'({1'b0, e_ctc} + 1'b1) * PCW'(i_tile);
        row_prod = PRW'({1'b0, e_ctr} + 1'b1) * PRW'(i_tile);
        col_fits = col_prod <= PCW'(i_width);
        row_fits = row_prod <= PRW'(i_height);
        col_last = col_fits && ((col_prod + PCW'(i_tile)) > PCW'(i_width));
        row_last = row_fits && ((row_prod + PRW'(i_tile)) > PRW'(i_height));
    end

    // Wrap points
    always_comb begin
        ocol_end = (TW'(e_ocol) + TW'(1)) >= i_tile;
        orow_end = (TW'(e_orow) + TW'(1)) >= i_tile;
        pcol_end = ({1'b0, e_pcol} + 1'b1) >= (CW+1)'(i_width);
        prow_end = ({1'b0, e_prow} + 1'b1) >= i_height;
    end

    // Work for this pixel
    always_comb begin
        o_op.count_en = col_fits && row_fits;
        o_op.first    = (e_orow == '0) && (e_ocol == '0);
        o_op.white    = |i_pixel;
        o_op.emit     = col_fits && row_fits && ocol_end && orow_end;
        o_op.last     = col_last && row_last;
        o_op.tile_row = e_ctr;
        o_op.tile_col = TILE_IDX_W'(e_ctc);
        o_addr        = e_ctc;
    end

    // Advance position
    always_comb begin
        n_pcol = e_pcol + 1'b1;
        n_ctc  = ocol_end ? e_ctc + 1'b1 : e_ctc;
        n_ocol = ocol_end ? '0 : e_ocol + 1'b1;
        n_prow = e_prow;
        n_ctr  = e_ctr;
        n_orow = e_orow;
        if (pcol_end) begin
            n_pcol = '0;
            n_ctc  = '0;
            n_ocol = '0;
            if (orow_end) begin
                n_orow = '0;
                n_ctr  = e_ctr + 1'b1;
            end else begin
                n_orow = e_orow + 1'b1;
            end
            if (prow_end) begin
                n_prow = '0;
                n_ctr  = '0;
                n_orow = '0;
            end else begin
                n_prow = e_prow + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcol <= '0;
            r_ctc  <= '0;
            r_ocol <= '0;
            r_prow <= '0;
            r_ctr  <= '0;
            r_orow <= '0;
        end else if (i_accept) begin
            r_pcol <= n_pcol;
            r_ctc  <= n_ctc;
            r_ocol <= n_ocol;
            r_prow <= n_prow;
            r_ctr  <= n_ctr;
            r_orow <= n_orow;
        end
    end

endmodule

[rtl/bbmf_acc.sv]
// White-count accumulator: read-modify-write of the column store with forwarding.
module bbmf_acc #(
    parameter int MAX_WIDTH = bbmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_TILE  = bbmf_pkg::DEF_MAX_TILE
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  bbmf_pkg::t_pix_op                   i_op,
    input  logic [$clog2(MAX_WIDTH)-1:0]        i_addr,
    input  logic [2*$clog2(MAX_TILE+1)-1:0]     i_tile_sq,
    output logic                                o_clearing,
    output logic                                o_res_valid,
    output bbmf_pkg::t_result                   o_result
);
    import bbmf_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int CNT_W = $clog2(MAX_TILE * MAX_TILE + 1);
    localparam int SQ_W  = 2 * $clog2(MAX_TILE + 1);
    localparam int CMPW  = CNT_W + 1 + SQ_W;

    t_pix_op          r_s1_op;
    logic             r_s1_valid;
    logic [CW-1:0]    r_s1_addr;
    logic             r_fwd_valid;
    logic [CW-1:0]    r_fwd_addr;
    logic [CNT_W-1:0] r_fwd_data;
    logic             r_clr_busy;
    logic [CW-1:0]    r_clr_addr;

    logic [CNT_W-1:0] ram_rdata, base, sum;
    logic             s1_we, ram_we, white_major;
    logic [CW-1:0]    ram_waddr;
    logic [CNT_W-1:0] ram_wdata;

    // Updated count: restart on the first pixel of a tile, take the
    // write of the cycle before when it hit the same column
    always_comb begin
        if (r_s1_op.first) begin
            base = '0;
        end else if (r_fwd_valid && (r_fwd_addr == r_s1_addr)) begin
            base = r_fwd_data;
        end else begin
            base = ram_rdata;
        end
        sum = (base == {CNT_W{1'b1}}) ? base : base + CNT_W'(r_s1_op.white);
        s1_we = r_s1_valid && r_s1_op.count_en;
        white_major = CMPW'({sum, 1'b0}) > CMPW'(i_tile_sq);
    end

    // Write port: clearing sweep after reset, then count write-back
    always_comb begin
        ram_we    = r_clr_busy || s1_we;
        ram_waddr = r_clr_busy ? r_clr_addr : r_s1_addr;
        ram_wdata = r_clr_busy ? '0 : sum;
    end

    bbmf_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_WIDTH)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_accept),
        .i_raddr (i_addr),
        .o_rdata (ram_rdata)
    );

    // Stage registers and forwarding copy of the last write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_s1_valid  <= i_accept;
            r_fwd_valid <= s1_we;
        end
        if (i_accept) begin
            r_s1_op   <= i_op;
            r_s1_addr <= i_addr;
        end
        r_fwd_addr <= r_s1_addr;
        r_fwd_data <= sum;
    end

    // Clearing sweep, one column per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == CW'(MAX_WIDTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_clearing  = r_clr_busy;
    assign o_res_valid = r_s1_valid && r_s1_op.emit;

    always_comb begin
        o_result.tile_row    = r_s1_op.tile_row;
        o_result.tile_col    = r_s1_op.tile_col;
        o_result.white_major = white_major;
        o_result.last        = r_s1_op.last;
    end

endmodule

[rtl/bbmf_outq.sv]
// Three-entry result queue between the accumulator and the output channel.
module bbmf_outq (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  bbmf_pkg::t_result                   i_data,
    input  logic                                i_pop,
    output logic                                o_valid,
    output bbmf_pkg::t_result                   o_head,
    output logic [bbmf_pkg::OUTQ_CNT_W-1:0]     o_count
);
    import bbmf_pkg::*;

    t_result               r_entry [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [OUTQ_CNT_W-1:0] r_count;

    // Store a pushed result
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_valid = r_count != '0;
    assign o_head  = r_entry[r_rd_ptr];
    assign o_count = r_count;

endmodule

[rtl/binary_block_majority_filter_core.sv]
// Top level of the binary block majority filter.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+----------------------------------------
//   pixel in | in        | i_valid / o_stall     | i_pixel, i_frame_start
//   tile out | out       | o_valid / i_stall     | o_tile_row, o_tile_col, o_fill_value,
//            |           |                       | o_last_tile
//   config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One pixel is taken per cycle while o_stall is low; after the transfer of a tile's last pixel
// its result passes the column store read and count update, then the result queue, to the output.
// After reset the column store is cleared, one entry a cycle, with o_stall high;
// configuration writes are taken throughout.
// o_stall also rises while the three-entry result queue could overflow, which
// happens only when the output side stalls.
module binary_block_majority_filter_core #(
    parameter int MAX_WIDTH = bbmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_TILE  = bbmf_pkg::DEF_MAX_TILE
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [bbmf_pkg::PIXEL_W-1:0]        i_pixel,
    input  logic                                i_frame_start,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [bbmf_pkg::ROW_W-1:0]          o_tile_row,
    output logic [bbmf_pkg::TILE_IDX_W-1:0]     o_tile_col,
    output logic [bbmf_pkg::FILL_W-1:0]         o_fill_value,
    output logic                                o_last_tile,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bbmf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bbmf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bbmf_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int TW   = $clog2(MAX_TILE + 1);
    localparam int SQ_W = 2 * TW;
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = ROW_W + 1;
    localparam int TC_W = (TW > CFG_TILE_W) ? TW : CFG_TILE_W;
    localparam int WC_W = (WW > CFG_DIM_W) ? WW : CFG_DIM_W;
    localparam int RST_T = (RST_TILE_SIZE > MAX_TILE) ? MAX_TILE : RST_TILE_SIZE;
    localparam int RST_W = (RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMAGE_WIDTH;
    localparam int RST_H = (RST_IMAGE_HEIGHT > HEIGHT_LIMIT) ? HEIGHT_LIMIT : RST_IMAGE_HEIGHT;

    logic [TW-1:0]   r_tile, n_tile;
    logic [SQ_W-1:0] r_tile_sq, n_tile_sq;
    logic [WW-1:0]   r_width, n_width;
    logic [HW-1:0]   r_height, n_height;
    logic [TC_W-1:0] tile_in;
    logic [WC_W-1:0] width_in;
    logic [CFG_DIM_W-1:0] height_in;

    logic                  accept, clearing, res_valid, out_pop;
    t_pix_op               op;
    logic [CW-1:0]         addr;
    t_result               result, head;
    logic [OUTQ_CNT_W-1:0] q_count;

    // Clamp written values into range
    always_comb begin
        tile_in   = TC_W'(i_cfg_data[CFG_TILE_W-1:0]);
        width_in  = WC_W'(i_cfg_data[CFG_DIM_W-1:0]);
        height_in = i_cfg_data[CFG_DIM_W-1:0];
        if (tile_in == '0) begin
            n_tile = TW'(1);
        end else if (tile_in > TC_W'(MAX_TILE)) begin
            n_tile = TW'(MAX_TILE);
        end else begin
            n_tile = TW'(tile_in);
        end
        if (width_in == '0) begin
            n_width = WW'(1);
        end else if (width_in > WC_W'(MAX_WIDTH)) begin
            n_width = WW'(MAX_WIDTH);
        end else begin
            n_width = WW'(width_in);
        end
        if (height_in == '0) begin
            n_height = HW'(1);
        end else if (height_in > CFG_DIM_W'(HEIGHT_LIMIT)) begin
            n_height = HW'(HEIGHT_LIMIT);
        end else begin
            n_height = HW'(height_in);
        end
        n_tile_sq = {{TW{1'b0}}, n_tile} * {{TW{1'b0}}, n_tile};
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile    <= TW'(RST_T);
            r_tile_sq <= SQ_W'(RST_T * RST_T);
            r_width   <= WW'(RST_W);
            r_height  <= HW'(RST_H);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TILE_SIZE: begin
                    r_tile    <= n_tile;
                    r_tile_sq <= n_tile_sq;
                end
                REG_IMAGE_WIDTH: begin
                    r_width <= n_width;
                end
                REG_IMAGE_HEIGHT: begin
                    r_height <= n_height;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Hold input while clearing or while the queue could fill up
    assign o_stall = clearing ||
                     (({1'b0, q_count} + {{OUTQ_CNT_W{1'b0}}, res_valid})
                      >= (OUTQ_CNT_W+1)'(OUTQ_DEPTH));
    assign accept  = i_valid && !o_stall;

    bbmf_pos #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_TILE  (MAX_TILE)
    ) u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .i_tile        (r_tile),
        .i_width       (r_width),
        .i_height      (r_height),
        .o_op          (op),
        .o_addr        (addr)
    );

    bbmf_acc #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_TILE  (MAX_TILE)
    ) u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_op        (op),
        .i_addr      (addr),
        .i_tile_sq   (r_tile_sq),
        .o_clearing  (clearing),
        .o_res_valid (res_valid),
        .o_result    (result)
    );

    assign out_pop = o_valid && !i_stall;

    bbmf_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (result),
        .i_pop   (out_pop),
        .o_valid (o_valid),
        .o_head  (head),
        .o_count (q_count)
    );

    // Drive result fields from the queue head
    assign o_tile_row   = head.tile_row;
    assign o_tile_col   = head.tile_col;
    assign o_fill_value = head.white_major ? FILL_WHITE : FILL_BLACK;
    assign o_last_tile  = head.last;

endmodule
